// ===== rtl/crc32bs_pkg.sv =====
// ----------------------------------------------------------------------------
// crc32bs_pkg - CRC-32 byte stream package
// Constants and the byte update function for the reflected CRC-32
// (polynomial 0xEDB88320, zero start value, no final XOR).
// ----------------------------------------------------------------------------
package crc32bs_pkg;

    localparam int unsigned CRC_W  = 32;
    localparam int unsigned BYTE_W = 8;

    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_INIT = '0;

    // One byte of the reflected CRC: XOR into the low byte, then eight
    // shift-right steps with a conditional polynomial XOR.
    function automatic logic [CRC_W-1:0] crc_update_byte(
        input logic [CRC_W-1:0]  crc_in,
        input logic [BYTE_W-1:0] data_in
    );
        logic [CRC_W-1:0] crc;
        crc = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data_in};
        for (int k = 0; k < BYTE_W; k++)
        begin
            if (crc[0])
                crc = (crc >> 1) ^ CRC_POLY;
            else
                crc = crc >> 1;
        end
        return crc;
    endfunction

endpackage

// ===== rtl/crc32bs_if.sv =====
// ----------------------------------------------------------------------------
// crc32bs_if - CRC-32 byte stream channels
// Valid/ready channels for the message bytes and for the finished CRC.
// ----------------------------------------------------------------------------

// Message byte channel
interface crc32bs_byte_if;
    logic                            valid;
    logic                            ready;
    logic [crc32bs_pkg::BYTE_W-1:0]  data_byte;
    logic                            last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// Finished CRC channel
interface crc32bs_crc_if;
    logic                            valid;
    logic                            ready;
    logic [crc32bs_pkg::CRC_W-1:0]   crc_value;

    modport source (output valid, output crc_value, input ready);
    modport sink   (input valid, input crc_value, output ready);
endinterface

// ===== rtl/crc32_byte_stream.sv =====
// ----------------------------------------------------------------------------
// crc32_byte_stream - running CRC-32 over a byte stream
// Reflected CRC-32, polynomial 0xEDB88320, zero start, no final XOR.
// ----------------------------------------------------------------------------
// Usage:
//   msg : sink channel, one message byte per transfer; last_byte marks the
//         final byte of a message.
//   crc : source channel, one transfer per message carrying the CRC of all
//         bytes up to and including the byte marked last.
// A byte is captured in an input register, the eight-step XOR network
// updates the running CRC from that register, and a finished CRC lands in
// the output register. The last byte of a message passes the input register
// and then the output register before its CRC is valid. Throughput: one
// byte per cycle, except while a last byte waits in the input register for
// the output register to free.
// Reset clears the running CRC to zero and drops both valid flags.
// When the receiver stalls with a CRC pending, bytes that are not last keep
// flowing; a last byte waits in the input register until the output
// register frees, and msg.ready drops only while that byte waits.
// After a last byte the running CRC returns to zero for the next message.
// ----------------------------------------------------------------------------
module crc32_byte_stream (
    input  logic              clk,
    input  logic              rst_n,
    crc32bs_byte_if.sink      msg,
    crc32bs_crc_if.source     crc
);

    logic                            stage_valid_reg;
    logic [crc32bs_pkg::BYTE_W-1:0]  stage_byte_reg;
    logic                            stage_last_reg;

    logic [crc32bs_pkg::CRC_W-1:0]   running_crc_reg;
    logic [crc32bs_pkg::CRC_W-1:0]   running_crc_next;

    logic                            out_valid_reg;
    logic [crc32bs_pkg::CRC_W-1:0]   crc_value_reg;

    logic                            advance;
    logic                            msg_xfer;

    // Stage moves on unless a last byte meets a full, stalled output
    assign advance  = stage_valid_reg && (!stage_last_reg || !out_valid_reg || crc.ready);
    assign msg.ready = !stage_valid_reg || advance;
    assign msg_xfer  = msg.valid && msg.ready;

    // Byte update network
    assign running_crc_next = crc32bs_pkg::crc_update_byte(running_crc_reg, stage_byte_reg);

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (msg.ready)
            stage_valid_reg <= msg.valid;
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (msg_xfer)
        begin
            stage_byte_reg <= msg.data_byte;
            stage_last_reg <= msg.last_byte;
        end
    end

    // Running CRC, cleared after a last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            running_crc_reg <= crc32bs_pkg::CRC_INIT;
        else if (advance)
            running_crc_reg <= stage_last_reg ? crc32bs_pkg::CRC_INIT : running_crc_next;
    end

    // Output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && stage_last_reg)
            out_valid_reg <= 1'b1;
        else if (crc.ready)
            out_valid_reg <= 1'b0;
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (advance && stage_last_reg)
            crc_value_reg <= running_crc_next;
    end

    assign crc.valid     = out_valid_reg;
    assign crc.crc_value = crc_value_reg;

endmodule
